// ===== src/xml_attribute_value_extractor_top_assert.svh =====
// Assertion macros shared by the checker of the attribute value extractor
`ifndef XML_ATTRIBUTE_VALUE_EXTRACTOR_TOP_ASSERT_SVH
`define XML_ATTRIBUTE_VALUE_EXTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define XAVE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define XAVE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/xave_pkg.sv =====
// Package: constants, entity tables and controller/datapath interface types
package xave_pkg;

   // Default for the longest attribute name
   localparam int unsigned NAME_CHARS_MAX = 16;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NAME_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NAME_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NAME_LEN  = 2'd2;

   // Scan phases
   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_VALUE  = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   // Characters of interest
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // Entities: text after the ampersand, left aligned, zero padded
   localparam int unsigned ENT_NUM       = 4;
   localparam int unsigned ENT_BUF_DEPTH = 4;
   localparam logic [1:0] ENT_QUOT = 2'd0;
   localparam logic [1:0] ENT_LT   = 2'd1;
   localparam logic [1:0] ENT_GT   = 2'd2;
   localparam logic [1:0] ENT_APOS = 2'd3;

   localparam logic [39:0] ENT_QUOT_TEXT = "quot;";
   localparam logic [39:0] ENT_LT_TEXT   = {"lt;", 16'h0000};
   localparam logic [39:0] ENT_GT_TEXT   = {"gt;", 16'h0000};
   localparam logic [39:0] ENT_APOS_TEXT = "apos;";

   // Character j (0..4) of entity e
   function automatic logic [7:0] ent_text_char(input logic [1:0] e, input logic [2:0] j);
      logic [39:0] t;
      logic [2:0]  sh;
      case (e)
         ENT_QUOT: t = ENT_QUOT_TEXT;
         ENT_LT:   t = ENT_LT_TEXT;
         ENT_GT:   t = ENT_GT_TEXT;
         ENT_APOS: t = ENT_APOS_TEXT;
         default:  t = '0;
      endcase
      sh = 3'd4 - j;
      return t[8*sh +: 8];
   endfunction

   // Length of entity e including the semicolon
   function automatic logic [2:0] ent_length(input logic [1:0] e);
      case (e)
         ENT_QUOT: return 3'd5;
         ENT_LT:   return 3'd3;
         ENT_GT:   return 3'd3;
         ENT_APOS: return 3'd5;
         default:  return 3'd5;
      endcase
   endfunction

   // Decoded character of entity e
   function automatic logic [7:0] ent_decoded(input logic [1:0] e);
      case (e)
         ENT_QUOT: return 8'h22;
         ENT_LT:   return 8'h3C;
         ENT_GT:   return 8'h3E;
         ENT_APOS: return 8'h27;
         default:  return 8'h00;
      endcase
   endfunction

   // Whitespace test (space, tab, LF, VT, FF, CR)
   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   // Controller to datapath commands
   typedef struct packed {
      logic       start;      // input transfer: update scan state, load result plan
      logic       emit_buf;   // send held entity byte at idx
      logic       emit_tail;  // send the plain or decoded character
      logic       emit_mark;  // send the end-of-line marker
      logic [1:0] idx;
   } xave_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [2:0] plan_cnt_in;   // plan of the byte now offered
      logic       plan_tail_in;
      logic       plan_mark_in;
      logic [2:0] plan_cnt;      // registered plan
      logic       plan_tail;
      logic       plan_mark;
      logic       out_free;      // output register can take a result
   } xave_status_type;

endpackage

// ===== src/xave_dp.sv =====
// Datapath: name registers, scan state, entity buffer, result plan, output register
module xave_dp import xave_pkg::*; #(
   parameter int unsigned MAX_NAME_CHARS = NAME_CHARS_MAX
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_write_data,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_line_end,
   input  xave_cmd_type         cmd,
   output xave_status_type      status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_value_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_line_done,
   output logic                 rsp_found
);

   localparam logic [4:0] MAX_LEN = 5'(MAX_NAME_CHARS);

   // Configuration
   logic [7:0] name_chars_ff [MAX_NAME_CHARS];
   logic [4:0] name_len_ff;

   // Line scan state
   logic       inq_ff, inq_in;
   logic       tok_ff, tok_in;
   logic [4:0] pos_ff, pos_in;
   logic [1:0] phase_ff, phase_in;
   logic       pend_ff, pend_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] ent_buf_ff [ENT_BUF_DEPTH];
   logic       buf_we;

   // Result plan
   logic [2:0] plan_cnt_ff, plan_cnt_in;
   logic       plan_tail_ff, plan_tail_in;
   logic       plan_mark_ff, plan_mark_in;
   logic [7:0] tail_byte_ff, tail_byte_in;
   logic       found_ff, found_in;

   // Output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_value_byte_ff;
   logic       rsp_byte_valid_ff;
   logic       rsp_line_done_ff;
   logic       rsp_found_ff;

   logic [4:0] eff_len;
   logic [4:0] pos_next;
   logic [7:0] pchar;
   logic       sep;
   logic       ent_complete;
   logic       ent_prefix;
   logic [7:0] ent_char;

   // Name character registers, eight per configuration word
   for (genvar gi = 0; gi < MAX_NAME_CHARS; gi++) begin : g_name
      localparam logic [CSR_IDX_W-1:0] WORD = (gi < 8) ? CSR_NAME_LOW : CSR_NAME_HIGH;
      always_ff @(posedge clock) begin
         if (reset) begin
            name_chars_ff[gi] <= '0;
         end else if (csr_write_en && (csr_index == WORD)) begin
            name_chars_ff[gi] <= csr_write_data[8*(gi%8) +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_len_ff <= 5'd1;
      end else if (csr_write_en && (csr_index == CSR_NAME_LEN)) begin
         name_len_ff <= csr_write_data[4:0];
      end
   end

   // Effective name length and the expected next byte of name="
   always_comb begin
      eff_len = name_len_ff;
      if (name_len_ff == 5'd0) eff_len = 5'd1;
      if (name_len_ff > MAX_LEN) eff_len = MAX_LEN;
   end

   always_comb begin
      pchar = CHAR_QUOTE;
      if (pos_ff == eff_len) pchar = CHAR_EQUAL;
      for (int i = 0; i < MAX_NAME_CHARS; i++) begin
         if ((pos_ff < eff_len) && (pos_ff == 5'(i))) pchar = name_chars_ff[i];
      end
   end

   assign pos_next = pos_ff + 5'd1;
   assign sep      = is_space(req_in_byte) && !inq_ff;

   // Entity match of held bytes plus the offered byte
   always_comb begin
      logic       ok;
      logic [2:0] n;
      ent_complete = 1'b0;
      ent_prefix   = 1'b0;
      ent_char     = 8'h00;
      n            = cnt_ff + 3'd1;
      for (int e = 0; e < ENT_NUM; e++) begin
         ok = (n <= ent_length(2'(e)));
         for (int j = 0; j < ENT_BUF_DEPTH; j++) begin
            if ((3'(j) < cnt_ff) && (ent_buf_ff[j] != ent_text_char(2'(e), 3'(j)))) ok = 1'b0;
         end
         if (req_in_byte != ent_text_char(2'(e), cnt_ff)) ok = 1'b0;
         if (ok && (n == ent_length(2'(e)))) begin
            ent_complete = 1'b1;
            ent_char     = ent_decoded(2'(e));
         end
         if (ok && (n < ent_length(2'(e)))) ent_prefix = 1'b1;
      end
   end

   // Next scan state and result plan for the offered byte
   always_comb begin
      inq_in       = inq_ff;
      tok_in       = tok_ff;
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      buf_we       = 1'b0;
      plan_cnt_in  = 3'd0;
      plan_tail_in = 1'b0;
      plan_mark_in = 1'b0;
      tail_byte_in = req_in_byte;
      found_in     = found_ff;

      case (phase_ff)
         PH_SEARCH: begin
            if (sep) begin
               tok_in = 1'b1;
               pos_in = 5'd0;
            end else if (tok_ff) begin
               if (req_in_byte == pchar) begin
                  pos_in = pos_next;
                  if (pos_next >= (eff_len + 5'd2)) begin
                     phase_in = PH_VALUE;
                     pend_in  = 1'b0;
                     cnt_in   = 3'd0;
                  end
               end else begin
                  tok_in = 1'b0;
               end
            end
         end
         PH_VALUE: begin
            if ((req_in_byte == CHAR_QUOTE) || sep) begin
               // value ends: held entity bytes go out literally
               plan_cnt_in = pend_ff ? cnt_ff : 3'd0;
               phase_in    = PH_DONE;
               pend_in     = 1'b0;
               cnt_in      = 3'd0;
            end else if (!pend_ff) begin
               if (req_in_byte == CHAR_AMP) begin
                  pend_in = 1'b1;
                  cnt_in  = 3'd0;
               end else begin
                  plan_tail_in = 1'b1;
               end
            end else if (ent_complete) begin
               plan_tail_in = 1'b1;
               tail_byte_in = ent_char;
               pend_in      = 1'b0;
               cnt_in       = 3'd0;
            end else if (ent_prefix) begin
               buf_we = 1'b1;
               cnt_in = cnt_ff + 3'd1;
            end else begin
               // unknown entity: drop the ampersand, replay held bytes
               plan_cnt_in = cnt_ff;
               cnt_in      = 3'd0;
               if (req_in_byte == CHAR_AMP) begin
                  pend_in = 1'b1;
               end else begin
                  pend_in      = 1'b0;
                  plan_tail_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      if (req_in_byte == CHAR_QUOTE) inq_in = !inq_ff;

      // Line end: flush a partial entity, then marker and line state reset
      if (req_line_end) begin
         if ((phase_in == PH_VALUE) && pend_in && (cnt_in != 3'd0)) plan_cnt_in = cnt_in;
         plan_mark_in = 1'b1;
         found_in     = (phase_in != PH_SEARCH);
         inq_in       = 1'b0;
         tok_in       = 1'b1;
         pos_in       = 5'd0;
         phase_in     = PH_SEARCH;
         pend_in      = 1'b0;
         cnt_in       = 3'd0;
      end
   end

   // Scan state and plan registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inq_ff       <= 1'b0;
         tok_ff       <= 1'b1;
         pos_ff       <= 5'd0;
         phase_ff     <= PH_SEARCH;
         pend_ff      <= 1'b0;
         cnt_ff       <= 3'd0;
         plan_cnt_ff  <= 3'd0;
         plan_tail_ff <= 1'b0;
         plan_mark_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else if (cmd.start) begin
         inq_ff       <= inq_in;
         tok_ff       <= tok_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         plan_cnt_ff  <= plan_cnt_in;
         plan_tail_ff <= plan_tail_in;
         plan_mark_ff <= plan_mark_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) tail_byte_ff <= tail_byte_in;
   end

   // Entity hold buffer, no reset
   always_ff @(posedge clock) begin
      if (cmd.start && buf_we) ent_buf_ff[cnt_ff[1:0]] <= req_in_byte;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_buf || cmd.emit_tail || cmd.emit_mark) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_buf) begin
         rsp_value_byte_ff <= ent_buf_ff[cmd.idx];
         rsp_byte_valid_ff <= 1'b1;
         rsp_line_done_ff  <= 1'b0;
         rsp_found_ff      <= 1'b0;
      end else if (cmd.emit_tail) begin
         rsp_value_byte_ff <= tail_byte_ff;
         rsp_byte_valid_ff <= 1'b1;
         rsp_line_done_ff  <= 1'b0;
         rsp_found_ff      <= 1'b0;
      end else if (cmd.emit_mark) begin
         rsp_value_byte_ff <= 8'h00;
         rsp_byte_valid_ff <= 1'b0;
         rsp_line_done_ff  <= 1'b1;
         rsp_found_ff      <= found_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_byte = rsp_value_byte_ff;
   assign rsp_byte_valid = rsp_byte_valid_ff;
   assign rsp_line_done  = rsp_line_done_ff;
   assign rsp_found      = rsp_found_ff;

   // Status to the controller
   assign status.plan_cnt_in  = plan_cnt_in;
   assign status.plan_tail_in = plan_tail_in;
   assign status.plan_mark_in = plan_mark_in;
   assign status.plan_cnt     = plan_cnt_ff;
   assign status.plan_tail    = plan_tail_ff;
   assign status.plan_mark    = plan_mark_ff;
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

endmodule

// ===== src/xave_ctrl.sv =====
// Controller: takes input transfers and steps through each byte's results
module xave_ctrl import xave_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  xave_status_type status,
   output xave_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUF  = 2'd1;
   localparam logic [1:0] ST_TAIL = 2'd2;
   localparam logic [1:0] ST_MARK = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] after_buf;
   logic [1:0] after_tail;

   assign req_ready = (state_ff == ST_IDLE);

   // Where to go once the held bytes or the tail byte are sent
   assign after_buf  = status.plan_tail ? ST_TAIL : (status.plan_mark ? ST_MARK : ST_IDLE);
   assign after_tail = status.plan_mark ? ST_MARK : ST_IDLE;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmd           = '0;
      cmd.idx       = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               idx_in    = 2'd0;
               if (status.plan_cnt_in != 3'd0) state_in = ST_BUF;
               else if (status.plan_tail_in)   state_in = ST_TAIL;
               else if (status.plan_mark_in)   state_in = ST_MARK;
            end
         end
         ST_BUF: begin
            if (status.out_free) begin
               cmd.emit_buf = 1'b1;
               if (({1'b0, idx_ff} + 3'd1) == status.plan_cnt) state_in = after_buf;
               else idx_in = idx_ff + 2'd1;
            end
         end
         ST_TAIL: begin
            if (status.out_free) begin
               cmd.emit_tail = 1'b1;
               state_in      = after_tail;
            end
         end
         ST_MARK: begin
            if (status.out_free) begin
               cmd.emit_mark = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== src/xml_attribute_value_extractor_top.sv =====
// Top level of the XML attribute value extractor
//
// Input channel req_*: one byte of a tag's attribute text per transfer, with
// req_line_end high on the last byte of the line. Result channel rsp_*: the
// decoded value characters of the first attribute named by the csr_* name
// registers (entities quot, lt, gt, apos decoded), then one end marker per
// line with rsp_line_done high and rsp_found telling whether it matched.
// Configuration: csr_write_en with csr_index 0/1 writes name characters
// 0-7/8-15, index 2 the name length; write only while the block is idle.
// Flow: a byte with no result leaves req_ready high for the next byte; a
// byte causing k results (k up to 6, entity replay plus end marker) holds
// it low while the controller sends one result per cycle, whenever the
// single output register is free, from the plan registered at the transfer.
// Reset clears the line state, the name registers (length 1) and the output.
// A stalled receiver holds the output register; the controller waits and
// req_ready stays low until all results of the current byte are sent.
module xml_attribute_value_extractor_top import xave_pkg::*; #(
   parameter int unsigned MAX_NAME_CHARS = NAME_CHARS_MAX
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_line_end,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_value_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_line_done,
   output logic                 rsp_found
);

   xave_cmd_type    cmd;
   xave_status_type status;

   xave_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   xave_dp #(
      .MAX_NAME_CHARS (MAX_NAME_CHARS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_in_byte    (req_in_byte),
      .req_line_end   (req_line_end),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value_byte (rsp_value_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_line_done  (rsp_line_done),
      .rsp_found      (rsp_found)
   );

endmodule

// ===== src/xave_checker.sv =====
// Port checker for the attribute value extractor, bound to the top level
`include "xml_attribute_value_extractor_top_assert.svh"

module xave_checker import xave_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 csr_write_en,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [63:0]          csr_write_data,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_line_end,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [7:0]           rsp_value_byte,
   input logic                 rsp_byte_valid,
   input logic                 rsp_line_done,
   input logic                 rsp_found
);

   logic csr_seen;
   assign csr_seen = csr_write_en && (csr_index != CSR_NAME_LEN) && (csr_write_data != '0);

   // A result is either a value character or the end marker, never both
   `XAVE_ASSERT_SAME(a_kind, clock, reset, rsp_valid, rsp_byte_valid != rsp_line_done, "result kind is not exactly one of character or marker")

   // found is only reported on the end marker
   `XAVE_ASSERT_SAME(a_found, clock, reset, rsp_valid && !rsp_line_done, !rsp_found, "found set outside the end marker")

   // The end marker must go out before another byte is taken
   `XAVE_ASSERT_NEXT(a_mark_pend, clock, reset, req_valid && req_ready && req_line_end && !csr_seen, !req_ready, "byte taken before the end marker of the line")

   // A stalled result holds
   `XAVE_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value_byte) && $stable(rsp_line_done), "stalled result changed")

endmodule

bind xml_attribute_value_extractor_top xave_checker u_checker (.*);
